// ===== hdl/fra_pkg.sv =====
// Shared types and constants for the free-run block allocator.
// Holds the transaction structs, operation and status codes and the FSM state type.
// No dependencies.
`default_nettype none

package fra_pkg;

    localparam int IDX_W = 12;
    localparam int LEN_W = 13;
    localparam int CNT_W = 8;

    localparam int MAP_DEPTH_DEF = 4096;
    localparam logic [LEN_W-1:0] GROUP_BLOCKS_RST = 13'd4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] start_index;
        logic [LEN_W-1:0] min_length;
        logic [LEN_W-1:0] max_length;
        logic             extend_only;
        logic [LEN_W-1:0] free_count;
    } t_fra_in;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] run_start;
        logic [LEN_W-1:0] run_length;
    } t_fra_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MARK,
        ST_FREE,
        ST_DONE
    } t_fra_state;

endpackage

`default_nettype wire

// ===== hdl/fra_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module fra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/free_run_block_allocator.sv =====
// Free-run block allocator: reference-count map in one RAM, scanned one entry per cycle.
// Allocate scans, decides, then marks the chosen entries; free decrements each of free_count entries, or is dropped.
// The RAM read port sets the pace: one map entry per cycle; one transaction at a time.
// Result is registered and becomes valid as the block returns to idle; the next one is taken while it waits.
// Reset is synchronous; afterwards a clearing pass zeroes every entry of the map.
// Depends on fra_pkg and fra_ram.
`default_nettype none

module free_run_block_allocator #(
    parameter int MAP_DEPTH = fra_pkg::MAP_DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire fra_pkg::t_fra_in          i_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output fra_pkg::t_fra_out              o_out,
    input  wire logic                      i_cfg_we,
    input  wire logic [fra_pkg::LEN_W-1:0] i_cfg_data
);

    import fra_pkg::*;

    localparam int AW = $clog2(MAP_DEPTH);
    localparam int PW = (AW + 1 > 14) ? AW + 1 : 14;

    t_fra_state r_state, n_state;

    logic [LEN_W-1:0] r_group_blocks;
    logic [PW-1:0]    w_limit;

    logic [PW-1:0]    r_pos, n_pos;
    logic [PW-1:0]    r_end, n_end;
    logic [PW-1:0]    r_run_from, n_run_from;
    logic [PW-1:0]    r_top_start, n_top_start;
    logic [LEN_W-1:0] r_run_len, n_run_len;
    logic [LEN_W-1:0] r_best_len, n_best_len;
    logic [LEN_W-1:0] r_min_len, n_min_len;
    logic [LEN_W-1:0] r_max_len, n_max_len;
    logic [LEN_W-1:0] r_mark_cnt, n_mark_cnt;
    logic             r_extend, n_extend;
    logic [AW-1:0]    r_clr, n_clr;
    t_fra_out         r_res, n_res;
    t_fra_out         r_out;
    logic             r_out_valid;

    logic             w_ram_we;
    logic [AW-1:0]    w_ram_waddr;
    logic [CNT_W-1:0] w_ram_wdata;
    logic [AW-1:0]    w_ram_raddr;
    logic [CNT_W-1:0] w_ram_rdata;

    logic             w_accept;
    logic             w_load_out;

    assign w_limit = (PW'(r_group_blocks) < PW'(MAP_DEPTH)) ? PW'(r_group_blocks)
                                                             : PW'(MAP_DEPTH);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_load_out  = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    fra_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr          <= '0;
            r_group_blocks <= GROUP_BLOCKS_RST;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (i_cfg_we) begin
                r_group_blocks <= i_cfg_data;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_end        <= n_end;
        r_run_from   <= n_run_from;
        r_top_start  <= n_top_start;
        r_run_len    <= n_run_len;
        r_best_len   <= n_best_len;
        r_min_len    <= n_min_len;
        r_max_len    <= n_max_len;
        r_mark_cnt   <= n_mark_cnt;
        r_extend     <= n_extend;
        r_res        <= n_res;
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        logic [PW-1:0]    v_next_pos;
        logic [LEN_W-1:0] v_run_inc;
        logic [PW-1:0]    v_start;
        logic [PW-1:0]    v_free_end;

        n_state      = r_state;
        n_pos        = r_pos;
        n_end        = r_end;
        n_run_from   = r_run_from;
        n_top_start  = r_top_start;
        n_run_len    = r_run_len;
        n_best_len   = r_best_len;
        n_min_len    = r_min_len;
        n_max_len    = r_max_len;
        n_mark_cnt   = r_mark_cnt;
        n_extend     = r_extend;
        n_res        = r_res;
        n_clr        = r_clr;
        w_ram_we     = 1'b0;
        w_ram_waddr  = r_pos[AW-1:0];
        w_ram_wdata  = '0;
        w_ram_raddr  = r_pos[AW-1:0];

        v_next_pos = r_pos + PW'(1);
        v_run_inc  = r_run_len + LEN_W'(1);
        v_start    = PW'(i_in.start_index);
        v_free_end = v_start + PW'(i_in.free_count);

        case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr;
                n_clr       = r_clr + AW'(1);
                if (r_clr == AW'(MAP_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_res = '{status: STATUS_OK, run_start: '0, run_length: '0};
                    if (i_in.operation == OP_FREE) begin
                        if (i_in.free_count != '0 && v_free_end <= w_limit) begin
                            w_ram_raddr = v_start[AW-1:0];
                            n_pos       = v_start;
                            n_end       = v_free_end;
                            n_state     = ST_FREE;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end else begin
                        n_min_len    = i_in.min_length;
                        n_max_len    = i_in.max_length;
                        n_extend     = i_in.extend_only;
                        n_top_start  = v_start;
                        n_best_len   = '0;
                        n_run_from   = v_start;
                        n_run_len    = '0;
                        if (i_in.max_length != '0 && v_start < w_limit) begin
                            w_ram_raddr = v_start[AW-1:0];
                            n_pos       = v_start;
                            n_state     = ST_SCAN;
                        end else begin
                            n_state = ST_DECIDE;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // Data for r_pos arrives now; prefetch the next entry while scanning on.
                if (w_ram_rdata != '0) begin
                    if (r_run_len > r_best_len) begin
                        n_top_start = r_run_from;
                        n_best_len  = r_run_len;
                    end
                    if (r_extend) begin
                        n_state = ST_DECIDE;
                    end else begin
                        n_run_len  = '0;
                        n_run_from = v_next_pos;
                    end
                end else begin
                    n_run_len = v_run_inc;
                    if (v_run_inc >= r_max_len) begin
                        n_top_start = r_run_from;
                        n_best_len  = v_run_inc;
                        n_state     = ST_DECIDE;
                    end
                end
                if (n_state == ST_SCAN) begin
                    if (v_next_pos < w_limit) begin
                        w_ram_raddr = v_next_pos[AW-1:0];
                        n_pos       = v_next_pos;
                    end else begin
                        // Scan hit the limit: let the trailing run compete.
                        if (n_run_len > n_best_len) begin
                            n_top_start = n_run_from;
                            n_best_len  = n_run_len;
                        end
                        n_state = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (r_best_len < r_min_len) begin
                    n_res   = '{status: STATUS_NO_SPACE, run_start: '0, run_length: '0};
                    n_state = ST_DONE;
                end else begin
                    n_res = '{status: STATUS_OK,
                              run_start: r_top_start[IDX_W-1:0],
                              run_length: r_best_len};
                    if (r_best_len != '0) begin
                        n_pos      = r_top_start;
                        n_mark_cnt = r_best_len;
                        n_state    = ST_MARK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MARK: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = CNT_W'(1);
                n_pos       = v_next_pos;
                n_mark_cnt  = r_mark_cnt - LEN_W'(1);
                if (r_mark_cnt == LEN_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_FREE: begin
                // Write back the decrement while reading the following entry.
                w_ram_we    = 1'b1;
                w_ram_wdata = w_ram_rdata - CNT_W'(1);
                if (v_next_pos < r_end) begin
                    w_ram_raddr = v_next_pos[AW-1:0];
                    n_pos       = v_next_pos;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != ST_IDLE)
        else $error("accepted transaction did not start work");

    a_scan_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_pos < w_limit)
        else $error("scan position past limit");

    a_scan_run_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_run_len < r_max_len)
        else $error("scan continued past max length");

    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FREE |-> r_pos < r_end)
        else $error("free position past end");

    a_mark_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MARK |-> r_mark_cnt != '0)
        else $error("mark with zero count");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for free_run_block_allocator: directed and random transactions,
// with results predicted in a scoreboard class that keeps its own copy of the count map.
// Depends on fra_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb;
    import fra_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 3000000;
    localparam int unsigned DRAIN_CYCLES  = 8200;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES   = 3000;

    typedef struct {
        int unsigned first;
        int unsigned len;
    } t_live_run;

    // Predicts allocator results from a private copy of the reference-count map.
    class t_run_map_checker;
        bit [CNT_W-1:0] block_refs [MAP_DEPTH_DEF];
        int unsigned    group_limit;
        t_fra_out       expected_runs [$];
        int unsigned    mismatches;

        function new();
            foreach (block_refs[i]) block_refs[i] = '0;
            group_limit = GROUP_BLOCKS_RST;
            mismatches  = 0;
        endfunction

        function void set_group_blocks(logic [LEN_W-1:0] value);
            group_limit = value;
        endfunction

        function t_fra_out note_request(t_fra_in req);
            int unsigned lim, first, top_start, best_len, run_len, run_from, pos, k;
            bit          stopped;
            t_fra_out    res;
            lim   = (group_limit < MAP_DEPTH_DEF) ? group_limit : MAP_DEPTH_DEF;
            first = req.start_index;
            res   = '0;
            res.status = STATUS_OK;
            if (req.operation == OP_FREE) begin
                // drop a free that would run past the group limit
                if (first + req.free_count <= lim) begin
                    for (k = 0; k < req.free_count; k++)
                        block_refs[first + k] = block_refs[first + k] - 8'd1;
                end
            end else begin
                top_start  = first;
                best_len   = 0;
                run_len    = 0;
                run_from   = first;
                pos        = first;
                stopped    = (req.max_length == '0);
                while (!stopped && pos < lim) begin
                    if (block_refs[pos] != '0) begin
                        if (run_len > best_len) begin
                            top_start  = run_from;
                            best_len   = run_len;
                        end
                        if (req.extend_only) begin
                            stopped = 1'b1;
                        end else begin
                            run_len  = 0;
                            run_from = pos + 1;
                        end
                    end else begin
                        run_len++;
                        if (run_len >= req.max_length) begin
                            top_start  = run_from;
                            best_len   = run_len;
                            stopped    = 1'b1;
                        end
                    end
                    pos++;
                end
                // a run that ends at the limit still competes
                if (!stopped && run_len > best_len) begin
                    top_start  = run_from;
                    best_len   = run_len;
                end
                if (best_len < req.min_length) begin
                    res.status = STATUS_NO_SPACE;
                end else begin
                    for (k = 0; k < best_len; k++)
                        if (top_start + k < MAP_DEPTH_DEF) block_refs[top_start + k] = 8'd1;
                    res.run_start  = top_start[IDX_W-1:0];
                    res.run_length = best_len[LEN_W-1:0];
                end
            end
            expected_runs.push_back(res);
            return res;
        endfunction

        function void check_result(t_fra_out got);
            t_fra_out want;
            if (expected_runs.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d start %0d length %0d",
                         $time, got.status, got.run_start, got.run_length);
                mismatches++;
                return;
            end
            want = expected_runs.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
            if (got.run_start !== want.run_start) begin
                $display("%0t: run_start mismatch: expected %0d, actual %0d",
                         $time, want.run_start, got.run_start);
                mismatches++;
            end
            if (got.run_length !== want.run_length) begin
                $display("%0t: run_length mismatch: expected %0d, actual %0d",
                         $time, want.run_length, got.run_length);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             in_valid = 1'b0;
    t_fra_in          in_data  = '0;
    logic             out_stall = 1'b0;
    logic             cfg_we   = 1'b0;
    logic [LEN_W-1:0] cfg_data = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_fra_out         o_out;

    t_run_map_checker sb;
    t_live_run        live_runs [$];
    int unsigned      gap_pct   = 6;
    bit               hold_req  = 1'b0;
    int unsigned      hold_cnt  = 0;
    int unsigned      cycle_cnt = 0;

    free_run_block_allocator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: check accepted results, stall at random or hold off on request.
    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) sb.check_result(o_out);
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < gap_pct);
        end
    end

    function automatic t_fra_in make_req(int unsigned op, int unsigned first, int unsigned minl,
                                         int unsigned maxl, int unsigned ext, int unsigned cnt);
        t_fra_in req;
        req.operation   = (op != 0) ? OP_FREE : OP_ALLOC;
        req.start_index = first[IDX_W-1:0];
        req.min_length  = minl[LEN_W-1:0];
        req.max_length  = maxl[LEN_W-1:0];
        req.extend_only = (ext != 0);
        req.free_count  = cnt[LEN_W-1:0];
        return req;
    endfunction

    task automatic send_request(input t_fra_in req);
        t_fra_out res;
        t_live_run run;
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        res = sb.note_request(req);
        if (req.operation == OP_ALLOC && res.status == STATUS_OK && res.run_length != '0) begin
            run.first = res.run_start;
            run.len   = res.run_length;
            live_runs.push_back(run);
        end
    endtask

    task automatic alloc(input int unsigned first, input int unsigned minl,
                         input int unsigned maxl, input int unsigned ext);
        send_request(make_req(0, first, minl, maxl, ext, $urandom_range(8191)));
    endtask

    task automatic free_run(input int unsigned first, input int unsigned cnt);
        send_request(make_req(1, first, $urandom_range(8191), $urandom_range(8191),
                              $urandom_range(1), cnt));
    endtask

    // Drain all results, let the block settle, then write the group size.
    task automatic write_group_blocks(input logic [LEN_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.expected_runs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_group_blocks(value);
    endtask

    task automatic random_phase(input int unsigned group_value, input int unsigned n_items,
                                input bit hold_output);
        int unsigned lim, pick, first, minl, maxl, cnt, slot;
        t_live_run   victim;
        write_group_blocks(group_value[LEN_W-1:0]);
        if (hold_output) hold_req = 1'b1;
        lim = (group_value < MAP_DEPTH_DEF) ? group_value : MAP_DEPTH_DEF;
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < 50 || (live_runs.size() == 0 && pick < 85)) begin
                first = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(lim - 1);
                case ($urandom_range(19))
                    0:       maxl = 0;
                    1:       maxl = 8191;
                    default: maxl = $urandom_range(lim / 2 + 1, 1);
                endcase
                minl = ($urandom_range(9) == 0) ? $urandom_range(8191)
                                                : $urandom_range(maxl / 2 + 1);
                alloc(first, minl, maxl, ($urandom_range(3) == 0));
            end else if (pick < 85) begin
                slot   = $urandom_range(live_runs.size() - 1);
                victim = live_runs[slot];
                live_runs.delete(slot);
                free_run(victim.first, victim.len);
            end else begin
                first = ($urandom_range(1) == 0) ? $urandom_range(4095) : $urandom_range(lim - 1);
                cnt   = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(8);
                free_run(first, cnt);
            end
        end
    endtask

    initial begin
        int unsigned phase;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // hold until the map clearing pass is over
        while (o_in_stall) @(posedge clk);

        write_group_blocks(13'd4096);
        alloc(0, 0, 0, 0);
        alloc(5, 1, 0, 0);
        alloc(0, 4, 8, 0);
        alloc(0, 1, 4, 1);
        alloc(4095, 1, 8191, 0);
        alloc(8, 4096, 8191, 0);
        free_run(4095, 1);
        free_run(0, 8);
        free_run(0, 1);
        free_run(4000, 8191);
        free_run(4095, 2);
        alloc(0, 4095, 8191, 0);
        free_run(1, 4095);
        alloc(4095, 0, 1, 1);
        free_run(4095, 1);
        free_run(4095, 0);
        alloc(100, 2, 3, 1);
        alloc(99, 1, 50, 1);
        alloc(98, 2, 10, 0);

        write_group_blocks(13'd1);
        alloc(0, 1, 8191, 0);
        free_run(1, 0);
        alloc(1, 0, 9, 0);

        write_group_blocks(13'd0);
        alloc(0, 0, 5, 0);
        free_run(0, 0);
        free_run(0, 1);
        alloc(0, 1, 5, 1);

        write_group_blocks(13'd8191);
        alloc(4090, 1, 8191, 0);
        free_run(4095, 1);

        for (phase = 0; phase < 8; phase++) begin
            gap_pct = (phase == 5) ? 0 : 6;
            random_phase((phase == 3) ? 4096 : $urandom_range(300, 16), 9, (phase == 2));
        end
        gap_pct = 6;

        in_valid <= 1'b0;
        while (sb.expected_runs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
